// ===== rtl/core/evest_pkg.sv =====
package evest_pkg;

  // Field widths
  localparam int RPM_W      = 24;
  localparam int COUNT_W    = 32;
  localparam int ELAPSED_W  = 20;
  localparam int DUTY_W     = 8;
  localparam int CPR_W      = 24;
  localparam int ALPHA_W    = 16;
  localparam int DB_W       = 8;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] CFG_CPR      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND = 2'd2;

  localparam logic [CPR_W-1:0]   CPR_RESET      = 24'd158042;
  localparam logic [ALPHA_W-1:0] ALPHA_RESET    = 16'd9830;
  localparam logic [DB_W-1:0]    DEADBAND_RESET = 8'd2;

  // RPM arithmetic: numerator is |delta| * 60e6 * 2^16, denominator cpr * elapsed.
  localparam int DEN_W   = CPR_W + ELAPSED_W;   // 44
  localparam int RPMK_W  = 26;
  localparam logic [RPMK_W-1:0] RPM_K = 26'd60000000;
  localparam int NUMP_W  = COUNT_W + RPMK_W;    // 58, numerator before the 2^16 shift
  localparam int NUM_W   = NUMP_W + 16;         // 74
  localparam int DSAT_W  = DEN_W + 24;          // 68

  localparam logic [RPM_W-1:0] RAW_MAX = 24'h7FFFFF;
  localparam logic [RPM_W-1:0] RAW_MIN = 24'h800000;

  // Exponential average
  localparam int EMA_W   = 40;
  localparam int DIFF_W  = EMA_W + 1;
  localparam int EPROD_W = DIFF_W + ALPHA_W + 1;

  // Shared divider partial remainder width
  localparam int REM_W = DEN_W;

  typedef enum logic {
    DIV_RPM = 1'b0,
    DIV_AVG = 1'b1
  } div_sel_t;

  typedef struct packed {
    logic     in_load;
    logic     prep;
    logic     raw_set;
    logic     div_start;
    div_sel_t div_sel;
    logic     raw_take;
    logic     ema_diff;
    logic     ema_mul;
    logic     ema_add;
    logic     ring_upd;
    logic     disp_zero;
    logic     disp_take;
    logic     out_load;
  } evest_cmd_t;

  typedef struct packed {
    logic is_rebase;
    logic need_div;
    logic div_busy;
    logic div_done;
    logic fill_zero;
    logic out_free;
  } evest_sts_t;

endpackage

// ===== rtl/core/evest_div.sv =====
module evest_div
  import evest_pkg::*;
#(
  parameter int QW = 27
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start_i,
  input  logic [REM_W-1:0]           rem_i,
  input  logic [QW-1:0]              dvd_i,
  input  logic [REM_W-1:0]           dvs_i,
  input  logic [$clog2(QW+1)-1:0]    cnt_i,
  output logic                       busy_o,
  output logic                       done_o,
  output logic [QW-1:0]              quo_o
);

  localparam int CNT_W = $clog2(QW + 1);

  logic [REM_W-1:0] rem_r, rem_nxt;
  logic [QW-1:0]    dvd_r, dvd_nxt;
  logic [REM_W-1:0] dvs_r, dvs_nxt;
  logic [QW-1:0]    quo_r, quo_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;

  logic [REM_W:0] trial;
  logic [REM_W:0] trial_sub;
  logic           ge;

  // One restoring step per cycle: shift in the next dividend bit, subtract if it fits.
  assign trial     = {rem_r, dvd_r[QW-1]};
  assign trial_sub = trial - {1'b0, dvs_r};
  assign ge        = (trial >= {1'b0, dvs_r});

  always_comb begin
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    dvs_nxt  = dvs_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start_i) begin
      rem_nxt  = rem_i;
      dvd_nxt  = dvd_i;
      dvs_nxt  = dvs_i;
      quo_nxt  = '0;
      cnt_nxt  = cnt_i;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? trial_sub[REM_W-1:0] : trial[REM_W-1:0];
      dvd_nxt = {dvd_r[QW-2:0], 1'b0};
      quo_nxt = {quo_r[QW-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
    quo_r <= quo_nxt;
  end

  assign busy_o = busy_r;
  assign done_o = done_r;
  assign quo_o  = quo_r;

endmodule

// ===== rtl/core/evest_dp.sv =====
module evest_dp
  import evest_pkg::*;
#(
  parameter int WINDOW_DEPTH = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                   in_cmd,
  input  logic [COUNT_W-1:0]     in_encoder_count,
  input  logic [ELAPSED_W-1:0]   in_elapsed_us,
  input  logic [DUTY_W-1:0]      in_drive_duty,
  input  logic                   in_update_average,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [RPM_W-1:0]       out_raw_rpm,
  output logic [RPM_W-1:0]       out_smoothed_rpm,
  output logic [RPM_W-1:0]       out_display_rpm,
  input  evest_cmd_t             cmd_i,
  output evest_sts_t             sts_o
);

  localparam int POS_W   = $clog2(WINDOW_DEPTH);
  localparam int FILL_W  = $clog2(WINDOW_DEPTH + 1);
  localparam int TOTAL_W = RPM_W + $clog2(WINDOW_DEPTH);
  localparam int QW      = TOTAL_W;
  localparam int DCNT_W  = $clog2(QW + 1);

  // Configuration registers
  logic [CPR_W-1:0]   cpr_r;
  logic [ALPHA_W-1:0] alpha_r;
  logic [DB_W-1:0]    db_r;

  // Captured input beat
  logic                 in_cmd_r;
  logic [COUNT_W-1:0]   count_r;
  logic [ELAPSED_W-1:0] elapsed_r;
  logic [DUTY_W-1:0]    duty_r;
  logic                 push_r;

  // Filter state
  logic [COUNT_W-1:0]      prev_r;
  logic signed [EMA_W-1:0] ema_r;
  logic [TOTAL_W-1:0]      total_r;
  logic [POS_W-1:0]        pos_r;
  logic [FILL_W-1:0]       fill_r;
  logic [RPM_W-1:0]        ring_mem [WINDOW_DEPTH];
  logic [RPM_W-1:0]        rd_q_r;

  // Working registers
  logic                     neg_r;
  logic                     qzero_r;
  logic [DEN_W-1:0]         den_r;
  logic [NUMP_W-1:0]        nump_r;
  logic [RPM_W-1:0]         raw_r;
  logic [RPM_W-1:0]         disp_r;
  logic signed [DIFF_W-1:0]  diff_r;
  logic signed [EPROD_W-1:0] eprod_r;

  // Output register
  logic             out_valid_r;
  logic [RPM_W-1:0] out_raw_r, out_smooth_r, out_disp_r;

  // Sample preparation
  logic [COUNT_W-1:0] delta;
  logic               delta_neg;
  logic [COUNT_W-1:0] mag;
  logic               gate;

  assign delta     = count_r - prev_r;
  assign delta_neg = delta[COUNT_W-1];
  assign mag       = delta_neg ? (~delta + 1'b1) : delta;
  assign gate      = (elapsed_r == '0) ||
                     ((duty_r == '0) && (mag <= {{(COUNT_W-DB_W){1'b0}}, db_r}));

  // Saturation test: quotient exceeds 2^23 exactly when num >= den * (2^23 + 1).
  logic [NUM_W-1:0]  num;
  logic [DSAT_W-1:0] dsat;
  logic              sat;

  assign num  = {nump_r, 16'b0};
  assign dsat = {1'b0, den_r, 23'b0} + {{(DSAT_W-DEN_W){1'b0}}, den_r};
  assign sat  = (den_r == '0) || (num >= {{(NUM_W-DSAT_W){1'b0}}, dsat});

  // Shared divider
  logic [REM_W-1:0]  div_rem;
  logic [QW-1:0]     div_dvd;
  logic [REM_W-1:0]  div_dvs;
  logic [DCNT_W-1:0] div_cnt;
  logic              div_busy, div_done;
  logic [QW-1:0]     div_quo;
  logic [TOTAL_W-1:0] abs_total;
  logic               total_neg;

  assign total_neg = total_r[TOTAL_W-1];
  assign abs_total = total_neg ? (~total_r + 1'b1) : total_r;

  always_comb begin
    if (cmd_i.div_sel == DIV_RPM) begin
      // Upper numerator bits preload the remainder; they sit below den when not saturated.
      div_rem = nump_r[NUMP_W-7:8];
      div_dvd = {nump_r[7:0], 16'b0, {(QW-RPM_W){1'b0}}};
      div_dvs = den_r;
      div_cnt = DCNT_W'(RPM_W);
    end else begin
      div_rem = '0;
      div_dvd = abs_total;
      div_dvs = {{(REM_W-FILL_W){1'b0}}, fill_r};
      div_cnt = DCNT_W'(QW);
    end
  end

  evest_div #(.QW(QW)) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (cmd_i.div_start),
    .rem_i   (div_rem),
    .dvd_i   (div_dvd),
    .dvs_i   (div_dvs),
    .cnt_i   (div_cnt),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  logic [RPM_W-1:0] q24;
  assign q24 = div_quo[RPM_W-1:0];

  // Ring bookkeeping
  logic [RPM_W-1:0]   smooth;
  logic               full;
  logic [RPM_W-1:0]   old_entry;
  logic               ring_we;

  assign smooth    = ema_r[EMA_W-1:16];
  assign full      = (fill_r == FILL_W'(WINDOW_DEPTH));
  assign old_entry = full ? rd_q_r : '0;
  assign ring_we   = cmd_i.ring_upd && push_r;

  // Configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cpr_r   <= CPR_RESET;
      alpha_r <= ALPHA_RESET;
      db_r    <= DEADBAND_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CPR:      cpr_r   <= cfg_wdata[CPR_W-1:0];
        CFG_ALPHA:    alpha_r <= cfg_wdata[ALPHA_W-1:0];
        CFG_DEADBAND: db_r    <= cfg_wdata[DB_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Filter state with reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r  <= '0;
      ema_r   <= '0;
      total_r <= '0;
      pos_r   <= '0;
      fill_r  <= '0;
    end else begin
      if (cmd_i.prep) begin
        prev_r <= count_r;
        if (in_cmd_r) begin
          ema_r   <= '0;
          total_r <= '0;
          pos_r   <= '0;
          fill_r  <= '0;
        end
      end
      if (cmd_i.ema_add) begin
        ema_r <= ema_r + EMA_W'(eprod_r >>> 16);
      end
      if (ring_we) begin
        total_r <= total_r - {{(TOTAL_W-RPM_W){old_entry[RPM_W-1]}}, old_entry}
                           + {{(TOTAL_W-RPM_W){smooth[RPM_W-1]}}, smooth};
        pos_r   <= (pos_r == POS_W'(WINDOW_DEPTH - 1)) ? '0 : pos_r + 1'b1;
        if (!full) begin
          fill_r <= fill_r + 1'b1;
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd_i.in_load) begin
      in_cmd_r  <= in_cmd;
      count_r   <= in_encoder_count;
      elapsed_r <= in_elapsed_us;
      duty_r    <= in_drive_duty;
      push_r    <= in_update_average;
    end
    if (cmd_i.prep) begin
      neg_r   <= delta_neg;
      qzero_r <= gate || (mag == '0);
      den_r   <= {{ELAPSED_W{1'b0}}, cpr_r} * {{CPR_W{1'b0}}, elapsed_r};
      nump_r  <= {{RPMK_W{1'b0}}, mag} * {{COUNT_W{1'b0}}, RPM_K};
      if (in_cmd_r) begin
        raw_r  <= '0;
        disp_r <= '0;
      end
    end
    if (cmd_i.raw_set) begin
      raw_r <= qzero_r ? '0 : (neg_r ? RAW_MIN : RAW_MAX);
    end
    if (cmd_i.raw_take) begin
      raw_r <= neg_r ? (~q24 + 1'b1) : (q24[RPM_W-1] ? RAW_MAX : q24);
    end
    if (cmd_i.ema_diff) begin
      diff_r <= {raw_r[RPM_W-1], raw_r, 16'b0} - {ema_r[EMA_W-1], ema_r};
    end
    if (cmd_i.ema_mul) begin
      eprod_r <= EPROD_W'(diff_r) * EPROD_W'($signed({1'b0, alpha_r}));
    end
    if (cmd_i.disp_zero) begin
      disp_r <= '0;
    end
    if (cmd_i.disp_take) begin
      disp_r <= total_neg ? (~q24 + 1'b1) : q24;
    end
  end

  // Ring memory, registered read at the current write position
  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring_mem[pos_r] <= smooth;
    end
    rd_q_r <= ring_mem[pos_r];
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.out_load) begin
      out_raw_r    <= raw_r;
      out_smooth_r <= smooth;
      out_disp_r   <= disp_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_raw_rpm      = out_raw_r;
  assign out_smoothed_rpm = out_smooth_r;
  assign out_display_rpm  = out_disp_r;

  assign sts_o.is_rebase = in_cmd_r;
  assign sts_o.need_div  = !qzero_r && !sat;
  assign sts_o.div_busy  = div_busy;
  assign sts_o.div_done  = div_done;
  assign sts_o.fill_zero = (fill_r == '0);
  assign sts_o.out_free  = !out_valid_r || out_ready;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(WINDOW_DEPTH))
    else $error("ring fill count above window depth");

  a_pos_tracks_fill: assert property (@(posedge clk) disable iff (!rst_n)
    !full |-> (pos_r == fill_r[POS_W-1:0]))
    else $error("ring position out of step with fill count");

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.div_start |-> (div_dvs != '0))
    else $error("divider started with zero divisor");
`endif

endmodule

// ===== rtl/core/evest_ctrl.sv =====
module evest_ctrl
  import evest_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  output evest_cmd_t cmd_o,
  input  evest_sts_t sts_i
);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b000_0000_0001,
    S_PREP  = 11'b000_0000_0010,
    S_CHECK = 11'b000_0000_0100,
    S_DIV1  = 11'b000_0000_1000,
    S_EDIFF = 11'b000_0001_0000,
    S_EMUL  = 11'b000_0010_0000,
    S_EADD  = 11'b000_0100_0000,
    S_RING  = 11'b000_1000_0000,
    S_AVG   = 11'b001_0000_0000,
    S_DIV2  = 11'b010_0000_0000,
    S_DONE  = 11'b100_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd_o     = '0;
    cmd_o.div_sel = DIV_RPM;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd_o.in_load = 1'b1;
          state_nxt     = S_PREP;
        end
      end
      S_PREP: begin
        cmd_o.prep = 1'b1;
        state_nxt  = sts_i.is_rebase ? S_DONE : S_CHECK;
      end
      S_CHECK: begin
        if (sts_i.need_div) begin
          cmd_o.div_start = 1'b1;
          state_nxt       = S_DIV1;
        end else begin
          cmd_o.raw_set = 1'b1;
          state_nxt     = S_EDIFF;
        end
      end
      S_DIV1: begin
        if (sts_i.div_done) begin
          cmd_o.raw_take = 1'b1;
          state_nxt      = S_EDIFF;
        end
      end
      S_EDIFF: begin
        cmd_o.ema_diff = 1'b1;
        state_nxt      = S_EMUL;
      end
      S_EMUL: begin
        cmd_o.ema_mul = 1'b1;
        state_nxt     = S_EADD;
      end
      S_EADD: begin
        cmd_o.ema_add = 1'b1;
        state_nxt     = S_RING;
      end
      S_RING: begin
        cmd_o.ring_upd = 1'b1;
        state_nxt      = S_AVG;
      end
      S_AVG: begin
        cmd_o.div_sel = DIV_AVG;
        if (sts_i.fill_zero) begin
          cmd_o.disp_zero = 1'b1;
          state_nxt       = S_DONE;
        end else begin
          cmd_o.div_start = 1'b1;
          state_nxt       = S_DIV2;
        end
      end
      S_DIV2: begin
        cmd_o.div_sel = DIV_AVG;
        if (sts_i.div_done) begin
          cmd_o.disp_take = 1'b1;
          state_nxt       = S_DONE;
        end
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef SYNTHESIS
  a_div_idle_at_start: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_o.div_start |-> !sts_i.div_busy)
    else $error("divider restarted while busy");
`endif

endmodule

// ===== rtl/core/encoder_velocity_estimator_core.sv =====
// Channel   Direction  Handshake               Beat contents
// --------  ---------  ----------------------  ------------------------------------------------
// in_*      input      in_valid / in_ready     cmd, encoder_count, elapsed_us, drive_duty,
//                                              update_average
// out_*     output     out_valid / out_ready   raw_rpm, smoothed_rpm, display_rpm (Q15.8)
// cfg_*     input      cfg_we, no wait         cfg_index selects counts_per_rev_x256,
//                                              ema_alpha_q16 or deadband_ticks
//
// A sample beat spends most of its time in the shared serial divider, which runs once for
// the RPM quotient and once for the window mean. A beat whose raw value is zero or
// saturated skips the first run, and one that finds the ring empty skips the second.
// A rebase beat skips both runs.
// Reset is synchronous and active low; it restores the register defaults and clears the
// count reference, the average, and the ring fill count, so no clearing pass is needed.
// A new beat is accepted while the previous result still waits in the output register;
// a stalled output holds the finished result and the next one waits in the datapath.
module encoder_velocity_estimator_core
  import evest_pkg::*;
#(
  parameter int WINDOW_DEPTH = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // Configuration writes
  input  logic                        cfg_we,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]       cfg_wdata,
  // Sample channel
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_cmd,
  input  logic signed [COUNT_W-1:0]   in_encoder_count,
  input  logic [ELAPSED_W-1:0]        in_elapsed_us,
  input  logic [DUTY_W-1:0]           in_drive_duty,
  input  logic                        in_update_average,
  // Result channel
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [RPM_W-1:0]     out_raw_rpm,
  output logic signed [RPM_W-1:0]     out_smoothed_rpm,
  output logic signed [RPM_W-1:0]     out_display_rpm
);

  // The controller sequences the beat; the datapath owns the filter state, the ring memory
  // and the divider. They talk only through these two structs.
  evest_cmd_t cmd;
  evest_sts_t sts;

  logic [RPM_W-1:0] raw_bits, smooth_bits, disp_bits;

  evest_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd_o    (cmd),
    .sts_i    (sts)
  );

  evest_dp #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_cmd            (in_cmd),
    .in_encoder_count  (in_encoder_count),
    .in_elapsed_us     (in_elapsed_us),
    .in_drive_duty     (in_drive_duty),
    .in_update_average (in_update_average),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_raw_rpm       (raw_bits),
    .out_smoothed_rpm  (smooth_bits),
    .out_display_rpm   (disp_bits),
    .cmd_i             (cmd),
    .sts_o             (sts)
  );

  // Results are carried as plain bit vectors inside; the ports present them as signed.
  assign out_raw_rpm      = raw_bits;
  assign out_smoothed_rpm = smooth_bits;
  assign out_display_rpm  = disp_bits;

endmodule
